// ----- rtl/dtpe_pkg.sv -----
// Package for the task graph priority engine: field widths, codes,
// sequencer states and the result record. No dependencies.
`default_nettype none
package dtpe_pkg;

    localparam int DEF_MAX_NODES  = 32;
    localparam int DEF_MAX_EDGES  = 128;
    localparam int DEF_MAX_DEGREE = 16;

    localparam int TID_W = 32;
    localparam int NI_W  = 8;
    localparam int IDX_W = 8;
    localparam int VAL_W = 64;
    localparam int NOW_W = 63;

    localparam logic [VAL_W-1:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [NOW_W-1:0] REL_RESET = 63'd1000000;

    typedef enum logic [2:0] {
        OP_INIT, OP_ADD_NODE, OP_ADD_EDGE, OP_SET_W,
        OP_GET_W, OP_GET_P, OP_HELT, OP_HLBS
    } op_t;

    typedef enum logic [2:0] {
        ST_OK, ST_FULL, ST_DUP, ST_UNKNOWN,
        ST_SELF, ST_ORDER, ST_DEGREE, ST_BAD_INDEX
    } status_t;

    typedef enum logic {ALU_ADD, ALU_SUB} alu_op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_SCAN_END, S_INS_WR,
        S_EDGE_CNT, S_DUP_RD, S_DUP_CMP, S_EDGE_CHK, S_ACCESS,
        S_RD_WAIT, S_DL, S_RANK_NEXT, S_RANK_C, S_RANK_RD,
        S_RANK_SUCC, S_RANK_CMP, S_RANK_WR, S_SORT_INIT, S_SORT_KEY,
        S_SORT_KEYW, S_SORT_J, S_SORT_A, S_SORT_CMP, S_SORT_PUT,
        S_FIN_RD, S_FIN_WR, S_DONE
    } seq_state_t;

    typedef struct packed {
        op_t               op;
        logic [TID_W-1:0]  tid;
        logic [TID_W-1:0]  tid_to;
        logic [NI_W-1:0]   node_index;
        logic [VAL_W-1:0]  weight;
        logic [NOW_W-1:0]  now;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
        logic [VAL_W-1:0]  deadline;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/dtpe_alu.sv -----
// Shared 64-bit add/subtract unit with a signed less-than compare.
// Depends on dtpe_pkg.
`default_nettype none
module dtpe_alu
    import dtpe_pkg::*;
(
    input  wire alu_op_t          op,
    input  wire logic [VAL_W-1:0] a,
    input  wire logic [VAL_W-1:0] b,
    output logic      [VAL_W-1:0] sum,
    output logic                  lt
);

    assign sum = (op == ALU_SUB) ? (a - b) : (a + b);
    assign lt  = $signed(a) < $signed(b);

endmodule
`default_nettype wire

// ----- rtl/dtpe_seq.sv -----
// Command sequencer: node/edge stores, graph walks and the sort, all
// through one shared adder/comparator. Depends on dtpe_pkg and dtpe_alu.
`default_nettype none
module dtpe_seq
    import dtpe_pkg::*;
#(
    parameter int MAX_NODES  = DEF_MAX_NODES,
    parameter int MAX_EDGES  = DEF_MAX_EDGES,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire cmd_t             cmd_in,
    input  wire logic [NOW_W-1:0] rel_deadline,
    input  wire logic             out_free,
    output logic                  ready,
    output logic                  done,
    output result_t               result
);

    localparam int NAW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int CW  = $clog2(MAX_DEGREE + 1);
    localparam int SAW = (MAX_NODES * MAX_DEGREE > 1) ? $clog2(MAX_NODES * MAX_DEGREE) : 1;
    localparam int SDEPTH = MAX_NODES * MAX_DEGREE;

    function automatic logic [SAW-1:0] succ_addr(input logic [NAW-1:0] node,
                                                 input logic [CW-1:0] slot);
        succ_addr = SAW'(int'(node) * MAX_DEGREE + int'(slot));
    endfunction

    seq_state_t state_reg, state_next;
    cmd_t       cmd_reg, cmd_next;
    logic [NCW-1:0] node_cnt_reg, node_cnt_next;
    logic [ECW-1:0] edge_cnt_reg, edge_cnt_next;
    logic [VAL_W-1:0] dl_reg, dl_next;
    logic [NCW-1:0] i_reg, i_next;
    logic [NCW-1:0] j_reg, j_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  c_reg, c_next;
    logic [NAW-1:0] f_reg, f_next, t_reg, t_next;
    logic           f_ok_reg, f_ok_next, t_ok_reg, t_ok_next;
    logic [VAL_W-1:0] acc_reg, acc_next, wv_reg, wv_next;
    status_t        st_reg, st_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [VAL_W-1:0] val_reg, val_next;

    // stores
    logic [TID_W-1:0] thr_mem  [MAX_NODES];
    logic [VAL_W-1:0] wgt_mem  [MAX_NODES];
    logic [VAL_W-1:0] pri_mem  [MAX_NODES];
    logic [CW-1:0]    cnt_mem  [MAX_NODES];
    logic [NAW-1:0]   succ_mem [SDEPTH];
    logic [NAW-1:0]   ord_mem  [MAX_NODES];

    logic thr_we, wgt_we, pri_we, cnt_we, succ_we, ord_we;
    logic thr_re, wgt_re, pri_re, cnt_re, succ_re, ord_re;
    logic [NAW-1:0] thr_wa, wgt_wa, pri_wa, cnt_wa, ord_wa;
    logic [NAW-1:0] thr_ra, wgt_ra, pri_ra, cnt_ra, ord_ra;
    logic [SAW-1:0] succ_wa, succ_ra;
    logic [VAL_W-1:0] wgt_wd, pri_wd;
    logic [CW-1:0]    cnt_wd;
    logic [NAW-1:0]   succ_wd, ord_wd;
    logic [TID_W-1:0] thr_rd;
    logic [VAL_W-1:0] wgt_rd, pri_rd;
    logic [CW-1:0]    cnt_rd;
    logic [NAW-1:0]   succ_rd, ord_rd;

    alu_op_t alu_op;
    logic [VAL_W-1:0] alu_a, alu_b, alu_sum;
    logic alu_lt;

    logic is_helt, ok_index, tbl_full, edges_full;
    logic [NCW-1:0] im1;
    op_t in_op;

    assign in_op      = cmd_in.op;
    assign is_helt    = (cmd_reg.op == OP_HELT);
    assign ok_index   = int'(cmd_reg.node_index) < int'(node_cnt_reg);
    assign tbl_full   = (node_cnt_reg == NCW'(MAX_NODES));
    assign edges_full = (edge_cnt_reg >= ECW'(MAX_EDGES));
    assign im1        = i_reg - 1'b1;

    dtpe_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .lt  (alu_lt)
    );

    always_ff @(posedge clk)
    begin
        if (thr_we) thr_mem[thr_wa] <= cmd_reg.tid;
        if (thr_re) thr_rd <= thr_mem[thr_ra];
        if (wgt_we) wgt_mem[wgt_wa] <= wgt_wd;
        if (wgt_re) wgt_rd <= wgt_mem[wgt_ra];
        if (pri_we) pri_mem[pri_wa] <= pri_wd;
        if (pri_re) pri_rd <= pri_mem[pri_ra];
        if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
        if (cnt_re) cnt_rd <= cnt_mem[cnt_ra];
        if (succ_we) succ_mem[succ_wa] <= succ_wd;
        if (succ_re) succ_rd <= succ_mem[succ_ra];
        if (ord_we) ord_mem[ord_wa] <= ord_wd;
        if (ord_re) ord_rd <= ord_mem[ord_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            node_cnt_reg <= '0;
            edge_cnt_reg <= '0;
            dl_reg       <= ALL_ONES;
        end
        else
        begin
            state_reg    <= state_next;
            node_cnt_reg <= node_cnt_next;
            edge_cnt_reg <= edge_cnt_next;
            dl_reg       <= dl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        c_reg    <= c_next;
        f_reg    <= f_next;
        t_reg    <= t_next;
        f_ok_reg <= f_ok_next;
        t_ok_reg <= t_ok_next;
        acc_reg  <= acc_next;
        wv_reg   <= wv_next;
        st_reg   <= st_next;
        idx_reg  <= idx_next;
        val_reg  <= val_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    case (in_op)
                        OP_INIT:     state_next = S_INS_WR;
                        OP_ADD_NODE: state_next = tbl_full ? S_DONE : S_SCAN_RD;
                        OP_ADD_EDGE: state_next = S_SCAN_RD;
                        OP_SET_W, OP_GET_W, OP_GET_P: state_next = S_ACCESS;
                        default:     state_next = S_DL;
                    endcase
                end
            S_SCAN_RD:   state_next = (i_reg == node_cnt_reg) ? S_SCAN_END : S_SCAN_CMP;
            S_SCAN_CMP:  state_next = S_SCAN_RD;
            S_SCAN_END:
                if (cmd_reg.op == OP_ADD_NODE)
                    state_next = f_ok_reg ? S_DONE : S_INS_WR;
                else if (!f_ok_reg || !t_ok_reg || edges_full)
                    state_next = S_DONE;
                else
                    state_next = S_EDGE_CNT;
            S_INS_WR:    state_next = S_DONE;
            S_EDGE_CNT:  state_next = S_DUP_RD;
            S_DUP_RD:    state_next = (k_reg == c_reg) ? S_EDGE_CHK : S_DUP_CMP;
            S_DUP_CMP:   state_next = (succ_rd == t_reg) ? S_DONE : S_DUP_RD;
            S_EDGE_CHK:  state_next = S_DONE;
            S_ACCESS:
                state_next = (ok_index && cmd_reg.op != OP_SET_W) ? S_RD_WAIT : S_DONE;
            S_RD_WAIT:   state_next = S_DONE;
            S_DL:        state_next = S_RANK_NEXT;
            S_RANK_NEXT:
                if (i_reg == '0)
                    state_next = is_helt ? S_SORT_INIT : S_DONE;
                else
                    state_next = S_RANK_C;
            S_RANK_C:    state_next = S_RANK_RD;
            S_RANK_RD:   state_next = (k_reg == c_reg) ? S_RANK_WR : S_RANK_SUCC;
            S_RANK_SUCC: state_next = S_RANK_CMP;
            S_RANK_CMP:  state_next = S_RANK_RD;
            S_RANK_WR:   state_next = S_RANK_NEXT;
            S_SORT_INIT: state_next = S_SORT_KEY;
            S_SORT_KEY:  state_next = (i_reg >= node_cnt_reg) ? S_FIN_RD : S_SORT_KEYW;
            S_SORT_KEYW: state_next = S_SORT_J;
            S_SORT_J:    state_next = (j_reg == '0) ? S_SORT_PUT : S_SORT_A;
            S_SORT_A:    state_next = S_SORT_CMP;
            S_SORT_CMP:  state_next = alu_lt ? S_SORT_PUT : S_SORT_J;
            S_SORT_PUT:  state_next = S_SORT_KEY;
            S_FIN_RD:    state_next = (i_reg == node_cnt_reg) ? S_DONE : S_FIN_WR;
            S_FIN_WR:    state_next = S_FIN_RD;
            S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        cmd_next = cmd_reg;
        node_cnt_next = node_cnt_reg;
        edge_cnt_next = edge_cnt_reg;
        dl_next = dl_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        c_next = c_reg;
        f_next = f_reg;
        t_next = t_reg;
        f_ok_next = f_ok_reg;
        t_ok_next = t_ok_reg;
        acc_next = acc_reg;
        wv_next = wv_reg;
        st_next = st_reg;
        idx_next = idx_reg;
        val_next = val_reg;
        thr_we = 1'b0; wgt_we = 1'b0; pri_we = 1'b0;
        cnt_we = 1'b0; succ_we = 1'b0; ord_we = 1'b0;
        thr_re = 1'b0; wgt_re = 1'b0; pri_re = 1'b0;
        cnt_re = 1'b0; succ_re = 1'b0; ord_re = 1'b0;
        thr_wa = node_cnt_reg[NAW-1:0];
        wgt_wa = node_cnt_reg[NAW-1:0];
        cnt_wa = node_cnt_reg[NAW-1:0];
        pri_wa = i_reg[NAW-1:0];
        ord_wa = j_reg[NAW-1:0];
        thr_ra = i_reg[NAW-1:0];
        wgt_ra = im1[NAW-1:0];
        cnt_ra = im1[NAW-1:0];
        pri_ra = i_reg[NAW-1:0];
        ord_ra = i_reg[NAW-1:0];
        succ_wa = succ_addr(f_reg, c_reg);
        succ_ra = succ_addr(f_reg, k_reg);
        wgt_wd = cmd_reg.weight;
        pri_wd = alu_sum;
        cnt_wd = '0;
        succ_wd = t_reg;
        ord_wd = j_reg[NAW-1:0];
        alu_op = ALU_ADD;
        alu_a = acc_reg;
        alu_b = pri_rd;
        ready = 1'b0;
        done = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    cmd_next  = cmd_in;
                    i_next    = '0;
                    f_ok_next = 1'b0;
                    t_ok_next = 1'b0;
                    st_next   = ST_OK;
                    idx_next  = '0;
                    val_next  = '0;
                    if (in_op == OP_INIT)
                    begin
                        node_cnt_next = '0;
                        edge_cnt_next = '0;
                        dl_next       = ALL_ONES;
                    end
                    else if (in_op == OP_ADD_NODE && tbl_full)
                        st_next = ST_FULL;
                end
            end
            S_SCAN_RD:
                thr_re = (i_reg != node_cnt_reg);
            S_SCAN_CMP:
            begin
                if (thr_rd == cmd_reg.tid && !f_ok_reg)
                begin
                    f_next = i_reg[NAW-1:0];
                    f_ok_next = 1'b1;
                end
                if (thr_rd == cmd_reg.tid_to && !t_ok_reg)
                begin
                    t_next = i_reg[NAW-1:0];
                    t_ok_next = 1'b1;
                end
                i_next = i_reg + 1'b1;
            end
            S_SCAN_END:
            begin
                cnt_ra = f_reg;
                if (cmd_reg.op == OP_ADD_NODE)
                begin
                    if (f_ok_reg)
                        st_next = ST_DUP;
                end
                else if (!f_ok_reg || !t_ok_reg)
                    st_next = ST_UNKNOWN;
                else if (edges_full)
                    st_next = ST_FULL;
                else
                    cnt_re = 1'b1;
            end
            S_INS_WR:
            begin
                thr_we = 1'b1;
                wgt_we = 1'b1;
                cnt_we = 1'b1;
                idx_next = IDX_W'(node_cnt_reg);
                node_cnt_next = node_cnt_reg + 1'b1;
            end
            S_EDGE_CNT:
            begin
                c_next = cnt_rd;
                k_next = '0;
            end
            S_DUP_RD:
                succ_re = (k_reg != c_reg);
            S_DUP_CMP:
            begin
                if (succ_rd == t_reg)
                    st_next = ST_DUP;
                k_next = k_reg + 1'b1;
            end
            S_EDGE_CHK:
            begin
                if (f_reg == t_reg)
                    st_next = ST_SELF;
                else if (f_reg > t_reg)
                    st_next = ST_ORDER;
                else if (c_reg >= CW'(MAX_DEGREE))
                    st_next = ST_DEGREE;
                else
                begin
                    succ_we = 1'b1;
                    cnt_we  = 1'b1;
                    cnt_wa  = f_reg;
                    cnt_wd  = c_reg + 1'b1;
                    idx_next = IDX_W'(edge_cnt_reg);
                    edge_cnt_next = edge_cnt_reg + 1'b1;
                end
            end
            S_ACCESS:
            begin
                wgt_wa = cmd_reg.node_index[NAW-1:0];
                wgt_ra = cmd_reg.node_index[NAW-1:0];
                pri_ra = cmd_reg.node_index[NAW-1:0];
                if (!ok_index)
                    st_next = ST_BAD_INDEX;
                else if (cmd_reg.op == OP_SET_W)
                    wgt_we = 1'b1;
                else if (cmd_reg.op == OP_GET_W)
                    wgt_re = 1'b1;
                else
                    pri_re = 1'b1;
            end
            S_RD_WAIT:
                val_next = (cmd_reg.op == OP_GET_W) ? wgt_rd : pri_rd;
            S_DL:
            begin
                alu_a = {1'b0, cmd_reg.now};
                alu_b = {1'b0, rel_deadline};
                dl_next = alu_sum;
                i_next = node_cnt_reg;
            end
            S_RANK_NEXT:
                if (i_reg != '0)
                begin
                    cnt_re = 1'b1;
                    wgt_re = 1'b1;
                    i_next = im1;
                end
            S_RANK_C:
            begin
                c_next = cnt_rd;
                wv_next = wgt_rd;
                k_next = '0;
                if (is_helt)
                    acc_next = '0;
                else
                    acc_next = (cnt_rd == '0) ? dl_reg : S64_MAX;
            end
            S_RANK_RD:
            begin
                succ_ra = succ_addr(i_reg[NAW-1:0], k_reg);
                succ_re = (k_reg != c_reg);
            end
            S_RANK_SUCC:
            begin
                pri_ra = succ_rd;
                pri_re = 1'b1;
            end
            S_RANK_CMP:
            begin
                // HELT keeps the largest successor rank, HLBS the smallest
                alu_a = is_helt ? acc_reg : pri_rd;
                alu_b = is_helt ? pri_rd : acc_reg;
                if (alu_lt)
                    acc_next = pri_rd;
                k_next = k_reg + 1'b1;
            end
            S_RANK_WR:
            begin
                alu_op = is_helt ? ALU_ADD : ALU_SUB;
                alu_a  = is_helt ? wv_reg : acc_reg;
                alu_b  = is_helt ? acc_reg : wv_reg;
                pri_we = 1'b1;
            end
            S_SORT_INIT:
            begin
                ord_we = 1'b1;
                ord_wa = '0;
                ord_wd = '0;
                i_next = NCW'(1);
            end
            S_SORT_KEY:
                if (i_reg >= node_cnt_reg)
                    i_next = '0;
                else
                    pri_re = 1'b1;
            S_SORT_KEYW:
            begin
                acc_next = pri_rd;
                j_next = i_reg;
            end
            S_SORT_J:
            begin
                ord_ra = im1[NAW-1:0];
                if (j_reg != '0)
                begin
                    ord_ra = j_reg[NAW-1:0] - 1'b1;
                    ord_re = 1'b1;
                end
            end
            S_SORT_A:
            begin
                pri_ra = ord_rd;
                pri_re = 1'b1;
            end
            S_SORT_CMP:
            begin
                alu_a = pri_rd;
                alu_b = acc_reg;
                if (!alu_lt)
                begin
                    ord_we = 1'b1;
                    ord_wd = ord_rd;
                    j_next = j_reg - 1'b1;
                end
            end
            S_SORT_PUT:
            begin
                ord_we = 1'b1;
                ord_wd = i_reg[NAW-1:0];
                i_next = i_reg + 1'b1;
            end
            S_FIN_RD:
                ord_re = (i_reg != node_cnt_reg);
            S_FIN_WR:
            begin
                alu_op = ALU_SUB;
                alu_a  = dl_reg;
                alu_b  = VAL_W'(i_reg);
                pri_wa = ord_rd;
                pri_we = 1'b1;
                i_next = i_reg + 1'b1;
            end
            S_DONE:
                done = out_free;
            default:
                ready = 1'b0;
        endcase
    end

    assign result.status   = st_reg;
    assign result.index    = (st_reg == ST_OK) ? idx_reg : '0;
    assign result.value    = (st_reg == ST_OK) ? val_reg : ALL_ONES;
    assign result.deadline = dl_reg;

endmodule
`default_nettype wire

// ----- rtl/dag_task_priority_engine.sv -----
// Top level of the task graph priority engine: stream ports, config
// register and output register. Depends on dtpe_pkg and dtpe_seq.
//
// One command word at a time; s_tready is low while a command runs. Timing
// is set by the single read port of each node/edge store and the one shared
// adder/comparator. HELT adds an insertion sort and the final priority
// pass to the rank walk that it shares with HLBS. The result word sits in
// an output register, so the next command is taken while it waits; a
// second finished result holds the sequencer until the first is taken.
`default_nettype none
module dag_task_priority_engine
    import dtpe_pkg::*;
#(
    parameter int MAX_NODES  = DEF_MAX_NODES,
    parameter int MAX_EDGES  = DEF_MAX_EDGES,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [199:0] s_tdata,   // tid, tid_to, node_index, weight, now, pad
    input  wire logic [2:0]   s_tuser,   // op
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,   // index, value, deadline
    output logic [2:0]        m_tuser,   // status
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [62:0]  cfg_data   // deadline offset
);

    logic [NOW_W-1:0] rel_reg;
    logic             m_tvalid_reg;
    logic [135:0]     m_tdata_reg;
    logic [2:0]       m_tuser_reg;
    logic             out_free, seq_ready, seq_done, start;
    cmd_t             cmd;
    result_t          res;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = seq_ready;
    assign start     = s_tvalid && seq_ready;

    assign cmd.op         = op_t'(s_tuser);
    assign cmd.tid        = s_tdata[31:0];
    assign cmd.tid_to     = s_tdata[63:32];
    assign cmd.node_index = s_tdata[71:64];
    assign cmd.weight     = s_tdata[135:72];
    assign cmd.now        = s_tdata[198:136];

    dtpe_seq #(
        .MAX_NODES  (MAX_NODES),
        .MAX_EDGES  (MAX_EDGES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd_in       (cmd),
        .rel_deadline (rel_reg),
        .out_free     (out_free),
        .ready        (seq_ready),
        .done         (seq_done),
        .result       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_reg      <= REL_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                rel_reg <= cfg_data;
            if (seq_done)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_done)
        begin
            m_tdata_reg <= {res.deadline, res.value, res.index};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

// ----- rtl/dtpe_checker.sv -----
// Port-level checks for the task graph priority engine, bound to the top
// level. Depends on dtpe_pkg.
`default_nettype none
module dtpe_checker
    import dtpe_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata,
    input wire logic [2:0]   m_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a command occupies the block for at least the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a command back to back");

    a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[71:8] == ALL_ONES)
                                           && (m_tdata[7:0] == 8'd0))
        else $error("failed command without -1 value and zero index");

    // no command finishes in the cycle it is taken
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result word appeared right after accept");

endmodule

bind dag_task_priority_engine dtpe_checker u_dtpe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ----- dv/dag_task_priority_engine_tb.sv -----
// Testbench for dag_task_priority_engine: drives graph commands on the input
// stream, predicts every result word in a scoreboard class and checks it.
// Depends on dtpe_pkg and the RTL top level.
`timescale 1ns / 1ps
module dag_task_priority_engine_tb;
    import dtpe_pkg::*;

    localparam int NMAX = DEF_MAX_NODES;
    localparam int EMAX = DEF_MAX_EDGES;
    localparam int DMAX = DEF_MAX_DEGREE;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [62:0]  cfg_data;

    int  errors;
    int  words_in;
    int  words_out;
    bit  idle_on;
    bit  hold_rx;
    int  hold_cycles;

    dag_task_priority_engine dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp);
        errors++;
        $display("ERROR t=%0t word %0d: %s got %h expected %h", $time, words_out, what,
                 got, exp);
    endtask

    function automatic bit s_less(logic [63:0] a, logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

    class graph_scoreboard;
        logic [62:0] rel_dl;
        int          n_nodes;
        int          n_edges;
        logic [31:0] thread_id [NMAX];
        logic [63:0] weight_of [NMAX];
        logic [63:0] prio_of [NMAX];
        bit          prio_set [NMAX];
        int          succ_cnt [NMAX];
        int          succ [NMAX][DMAX];
        logic [63:0] abs_dl;
        result_t     pending [$];

        function new();
            rel_dl = REL_RESET;
            n_nodes = 0;
            n_edges = 0;
            abs_dl = ALL_ONES;
            foreach (prio_set[i]) prio_set[i] = 0;
        endfunction

        function int lookup(logic [31:0] t);
            for (int i = 0; i < n_nodes; i++)
                if (thread_id[i] == t) return i;
            return -1;
        endfunction

        function status_t add_node(logic [31:0] t, logic [63:0] w, output int idx);
            idx = 0;
            if (n_nodes >= NMAX) return ST_FULL;
            if (lookup(t) >= 0) return ST_DUP;
            thread_id[n_nodes] = t;
            weight_of[n_nodes] = w;
            succ_cnt[n_nodes] = 0;
            idx = n_nodes;
            n_nodes++;
            return ST_OK;
        endfunction

        function status_t add_edge(logic [31:0] ft, logic [31:0] tt, output int idx);
            int f;
            int t;
            idx = 0;
            f = lookup(ft);
            t = lookup(tt);
            if (f < 0 || t < 0) return ST_UNKNOWN;
            if (n_edges >= EMAX) return ST_FULL;
            for (int k = 0; k < succ_cnt[f]; k++)
                if (succ[f][k] == t) return ST_DUP;
            if (f == t) return ST_SELF;
            if (f > t) return ST_ORDER;
            if (succ_cnt[f] >= DMAX) return ST_DEGREE;
            succ[f][succ_cnt[f]] = t;
            succ_cnt[f]++;
            idx = n_edges;
            n_edges++;
            return ST_OK;
        endfunction

        function void rank_helt();
            int          order [NMAX];
            logic [63:0] best;
            int          a;
            for (int i = n_nodes - 1; i >= 0; i--)
            begin
                best = 0;
                for (int k = 0; k < succ_cnt[i]; k++)
                    if (s_less(best, prio_of[succ[i][k]])) best = prio_of[succ[i][k]];
                prio_of[i] = weight_of[i] + best;
            end
            for (int i = 0; i < n_nodes; i++) order[i] = i;
            for (int i = 1; i < n_nodes; i++)
                for (int j = i; j > 0; j--)
                begin
                    if (s_less(prio_of[order[j-1]], prio_of[order[j]])) break;
                    a = order[j-1];
                    order[j-1] = order[j];
                    order[j] = a;
                end
            for (int i = 0; i < n_nodes; i++)
            begin
                prio_of[order[i]] = abs_dl - 64'(i);
                prio_set[order[i]] = 1;
            end
        endfunction

        function void latest_start();
            logic [63:0] m;
            for (int i = n_nodes - 1; i >= 0; i--)
            begin
                if (succ_cnt[i] == 0) m = abs_dl;
                else
                begin
                    m = S64_MAX;
                    for (int k = 0; k < succ_cnt[i]; k++)
                        if (s_less(prio_of[succ[i][k]], m)) m = prio_of[succ[i][k]];
                end
                prio_of[i] = m - weight_of[i];
                prio_set[i] = 1;
            end
        endfunction

        // notes an accepted command word and queues its predicted result
        function void note_command(cmd_t c);
            result_t r;
            int      idx;
            bit      ok_ix;
            r.status = ST_OK;
            r.value = 0;
            idx = 0;
            ok_ix = c.node_index < n_nodes;
            case (c.op)
                OP_INIT:
                begin
                    n_nodes = 0;
                    n_edges = 0;
                    abs_dl = ALL_ONES;
                    r.status = add_node(c.tid, c.weight, idx);
                end
                OP_ADD_NODE: r.status = add_node(c.tid, c.weight, idx);
                OP_ADD_EDGE: r.status = add_edge(c.tid, c.tid_to, idx);
                OP_SET_W:
                    if (ok_ix) weight_of[c.node_index] = c.weight;
                    else r.status = ST_BAD_INDEX;
                OP_GET_W:
                    if (ok_ix) r.value = weight_of[c.node_index];
                    else r.status = ST_BAD_INDEX;
                OP_GET_P:
                    if (ok_ix) r.value = prio_of[c.node_index];
                    else r.status = ST_BAD_INDEX;
                default:
                begin
                    abs_dl = {1'b0, c.now} + {1'b0, rel_dl};
                    if (c.op == OP_HELT) rank_helt();
                    else latest_start();
                end
            endcase
            if (r.status != ST_OK)
            begin
                idx = 0;
                r.value = ALL_ONES;
            end
            r.index = idx[7:0];
            r.deadline = abs_dl;
            pending.push_back(r);
        endfunction

        task check_result(result_t got);
            result_t exp;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected word", got.value, 0);
                return;
            end
            exp = pending.pop_front();
            if (got.status != exp.status) report_mismatch("status", got.status, exp.status);
            if (got.index != exp.index) report_mismatch("index", got.index, exp.index);
            if (got.value != exp.value) report_mismatch("value", got.value, exp.value);
            if (got.deadline != exp.deadline)
                report_mismatch("deadline", got.deadline, exp.deadline);
        endtask
    endclass

    graph_scoreboard sb;

    // result side: random backpressure plus a long hold on request
    initial
    begin
        result_t r;
        m_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                r.status = status_t'(m_tuser);
                r.index = m_tdata[7:0];
                r.value = m_tdata[71:8];
                r.deadline = m_tdata[135:72];
                words_out++;
                sb.check_result(r);
            end
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                hold_cycles++;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // s_tvalid stays high after an accept; the next word, an idle gap or
    // drain() takes it down
    task automatic send_cmd(input op_t op, input logic [31:0] tid, input logic [31:0] tid_to,
                            input logic [7:0] ni, input logic [63:0] w,
                            input logic [62:0] now);
        cmd_t c;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        c.op = op;
        c.tid = tid;
        c.tid_to = tid_to;
        c.node_index = ni;
        c.weight = w;
        c.now = now;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, now, w, ni, tid_to, tid};
        @(posedge clk iff s_tready);
        sb.note_command(c);
        words_in++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_rel(input logic [62:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk iff cfg_ready);
        sb.rel_dl = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] small_w();
        case ($urandom_range(0, 5))
            0: return rnd64();
            1: return 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
            2: return 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
            default: return $urandom_range(0, 1000) - 500;
        endcase
    endfunction

    function automatic logic [62:0] rnd_now();
        return ($urandom_range(0, 3) == 0) ? rnd64() : {$urandom_range(0, 100000)};
    endfunction

    // picks an index that only hits a node whose priority has been written
    function automatic logic [7:0] prio_index();
        logic [7:0] i;
        i = $urandom_range(0, 255);
        if (i < sb.n_nodes && !sb.prio_set[i]) i = 8'd255;
        return i;
    endfunction

    // one random graph: a chain of nodes, forward edges, a few broken ones
    task automatic random_graph(input int nn);
        logic [31:0] base;
        int          f;
        int          t;
        base = $urandom();
        send_cmd(OP_INIT, base, 0, 0, small_w(), 0);
        for (int i = 1; i < nn; i++)
            send_cmd(OP_ADD_NODE, (i % 9 == 8) ? base : base + i, 0, 0, small_w(), 0);
        repeat ($urandom_range(0, 3 * nn))
        begin
            f = $urandom_range(0, nn - 1);
            t = $urandom_range(0, nn - 1);
            if ($urandom_range(0, 4) != 0 && f > t)
            begin
                int x = f;
                f = t;
                t = x;
            end
            send_cmd(OP_ADD_EDGE, base + f,
                     ($urandom_range(0, 15) == 0) ? $urandom() : base + t, 0, 0, 0);
        end
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 5))
                0: send_cmd(OP_SET_W, 0, 0, $urandom_range(0, nn), small_w(), 0);
                1: send_cmd(OP_GET_W, 0, 0, $urandom_range(0, 255), 0, 0);
                2: send_cmd(OP_GET_P, 0, 0, prio_index(), 0, 0);
                3: send_cmd(OP_HELT, 0, 0, 0, 0, rnd_now());
                default: send_cmd(OP_HLBS, 0, 0, 0, 0, rnd_now());
            endcase
        end
        send_cmd($urandom_range(0, 1) ? OP_HELT : OP_HLBS, 0, 0, 0, 0, rnd_now());
        for (int i = 0; i < nn; i++)
            if ($urandom_range(0, 2) == 0) send_cmd(OP_GET_P, 0, 0, i, 0, 0);
    endtask

    initial
    begin
        #50_000_000;
        $display("dag_task_priority_engine_tb: FAIL");
        $finish;
    end

    initial
    begin
        errors = 0;
        words_in = 0;
        words_out = 0;
        idle_on = 1;
        hold_rx = 0;
        hold_cycles = 0;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty graph, extremes, the duplicate, self, order, unknown and bad-index codes
        send_cmd(OP_HLBS, 0, 0, 0, 0, 0);
        send_cmd(OP_GET_W, 0, 0, 0, 0, 0);
        send_cmd(OP_INIT, 32'hFFFF_FFFF, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        send_cmd(OP_ADD_NODE, 32'h0, 0, 0, 64'h8000_0000_0000_0000, 0);
        send_cmd(OP_ADD_NODE, 32'hFFFF_FFFF, 0, 0, 5, 0);
        send_cmd(OP_ADD_NODE, 32'h5, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_cmd(OP_ADD_EDGE, 32'hFFFF_FFFF, 32'h0, 0, 0, 0);
        send_cmd(OP_ADD_EDGE, 32'hFFFF_FFFF, 32'h0, 0, 0, 0);
        send_cmd(OP_ADD_EDGE, 32'h0, 32'h0, 0, 0, 0);
        send_cmd(OP_ADD_EDGE, 32'h5, 32'h0, 0, 0, 0);
        send_cmd(OP_ADD_EDGE, 32'h0, 32'h1234, 0, 0, 0);
        send_cmd(OP_ADD_EDGE, 32'h0, 32'h5, 0, 0, 0);
        send_cmd(OP_SET_W, 0, 0, 8'd1, 64'h8000_0000_0000_0000, 0);
        send_cmd(OP_SET_W, 0, 0, 8'd255, 1, 0);
        send_cmd(OP_GET_W, 0, 0, 8'd1, 0, 0);
        send_cmd(OP_HELT, 0, 0, 0, 0, 63'h7FFF_FFFF_FFFF_FFFF);
        send_cmd(OP_GET_P, 0, 0, 8'd0, 0, 0);
        send_cmd(OP_GET_P, 0, 0, 8'd2, 0, 0);
        send_cmd(OP_GET_P, 0, 0, 8'd3, 0, 0);
        send_cmd(OP_HLBS, 0, 0, 0, 0, 0);
        send_cmd(OP_GET_P, 0, 0, 8'd1, 0, 0);

        // table full on nodes, then degree full, then table full on edges
        write_rel(63'd1);
        send_cmd(OP_INIT, 100, 0, 0, 1, 0);
        for (int i = 1; i < NMAX; i++) send_cmd(OP_ADD_NODE, 100 + i, 0, 0, i, 0);
        send_cmd(OP_ADD_NODE, 999, 0, 0, 0, 0);
        for (int i = 1; i <= DMAX + 1; i++) send_cmd(OP_ADD_EDGE, 100, 100 + i, 0, 0, 0);
        for (int f = 1; f < NMAX && sb.n_edges < EMAX + 1; f++)
            for (int t = f + 1; t < NMAX && t <= f + 9; t++)
                send_cmd(OP_ADD_EDGE, 100 + f, 100 + t, 0, 0, 0);
        send_cmd(OP_HELT, 0, 0, 0, 0, 63'd7);
        send_cmd(OP_HLBS, 0, 0, 0, 0, 63'd9);

        // long receiver hold: the output register fills and input stalls
        hold_rx = 1;
        fork
            begin
                for (int i = 0; i < 6; i++) send_cmd(OP_GET_W, 0, 0, i, 0, 0);
            end
            begin
                while (hold_cycles < 400) @(posedge clk);
                hold_rx = 0;
            end
        join

        write_rel(63'h7FFF_FFFF_FFFF_FFFF);
        send_cmd(OP_HLBS, 0, 0, 0, 0, 63'h7FFF_FFFF_FFFF_FFFF);
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: write_rel(63'd1000000);
                1: write_rel({$urandom(), $urandom()});
                2: write_rel(63'd1);
                default: write_rel($urandom_range(1, 50000));
            endcase
            while (words_in < 400 + 250 * (p + 1))
                random_graph(($urandom_range(0, 9) == 0) ? NMAX : $urandom_range(1, 10));
            drain();
        end
        idle_on = 0;
        while (words_in < 1700) random_graph($urandom_range(1, 12));

        drain();
        $display("Covered %0d commands and %0d results over random graphs, all status codes,",
                 words_in, words_out);
        $display("both priority rules, several relative deadlines and output backpressure.");
        if (errors == 0 && sb.pending.size() == 0)
            $display("dag_task_priority_engine_tb: PASS");
        else
            $display("dag_task_priority_engine_tb: FAIL");
        $finish;
    end

endmodule
